// ===== rtl/lrg_pkg.sv =====
`timescale 1ns / 1ps

package lrg_pkg;

    localparam int unsigned SEED_W  = 32;
    localparam int unsigned RAW_W   = SEED_W - 1;
    localparam int unsigned SPAN_W  = SEED_W + 1;
    localparam int unsigned BITCNT_W = $clog2(RAW_W);

    localparam logic [SEED_W-1:0] LCG_MULT     = 32'd314159265;
    localparam logic [SEED_W-1:0] LCG_INC      = 32'd13579;
    localparam logic [SEED_W-1:0] LCG_MODULUS  = 32'hFFFF_FFFF;
    localparam logic [SEED_W-1:0] FALLBACK_RST = 32'd1;
    localparam logic [SEED_W-1:0] SEED_RST     = 32'd1;

    typedef enum logic [1:0] {
        KIND_RESEED = 2'd0,
        KIND_RAW    = 2'd1,
        KIND_RANGE  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    // x mod 3 by folding base-4 digits (4 == 1 mod 3)
    function automatic logic [1:0] mod3(input logic [SEED_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        logic [1:0] r;
        s1 = '0;
        for (int i = 0; i < SEED_W / 2; i++) begin
            s1 = s1 + {4'd0, x[2*i +: 2]};
        end
        s2 = {2'd0, s1[5:4]} + {2'd0, s1[3:2]} + {2'd0, s1[1:0]};
        s3 = {1'b0, s2[3:2]} + {1'b0, s2[1:0]};
        if (s3 >= 3'd6) begin
            r = 2'(s3 - 3'd6);
        end
        else if (s3 >= 3'd3) begin
            r = 2'(s3 - 3'd3);
        end
        else begin
            r = s3[1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/lcg_random_range_generator.sv =====
`timescale 1ns / 1ps
// Sequence: reseed or unused kind go straight to the output state; a raw draw or inverted
// bounds advance the seed 1 to 3 times (each advance: multiply, then add/fold);
// a ranged draw then adds 31 restoring remainder steps.
// One item at a time: the next request is accepted only after the result is loaded into the
// output register, and that load waits while the previous output beat waits for m_axis_tready.
// Reset (rst_n, async, active low): seed 1, fallback seed 1, idle, no output beat.
module lcg_random_range_generator
    import lrg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // config: fallback_seed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // [31:0] seed_value, [63:32] low_bound,
                                        // [95:64] high_bound
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic        m_axis_tuser    // [0] range_error
);

    state_t              state_reg, state_next;
    logic [SEED_W-1:0]   seed_reg, seed_next;
    logic [SEED_W-1:0]   fallback_reg;
    logic [SEED_W-1:0]   prod_reg, prod_next;
    logic [1:0]          adv_cnt_reg, adv_cnt_next;   // advances left after this one
    kind_t               kind_reg, kind_next;
    logic [SEED_W-1:0]   low_reg, low_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic                err_reg, err_next;
    logic [RAW_W-1:0]    raw_reg, raw_next;           // dividend, shifted out msb first
    logic [SEED_W-1:0]   rem_reg, rem_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [SEED_W-1:0]   res_reg, res_next;

    logic                out_valid_reg;
    logic [SEED_W-1:0]   out_data_reg;
    logic                out_err_reg;

    logic                in_beat;
    logic                out_free;
    logic [SEED_W-1:0]   lcg_sum;
    logic [SEED_W-1:0]   lcg_fold;
    logic [SPAN_W-1:0]   rem_shift;
    logic [SPAN_W-1:0]   rem_sub;
    logic [SEED_W-1:0]   in_seed;
    logic [SEED_W-1:0]   in_low;
    logic [SEED_W-1:0]   in_high;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

    assign in_seed = s_axis_tdata[31:0];
    assign in_low  = s_axis_tdata[63:32];
    assign in_high = s_axis_tdata[95:64];

    // second half of one advance: add increment, fold 2^32-1 to 0
    assign lcg_sum  = prod_reg + LCG_INC;
    assign lcg_fold = (lcg_sum == LCG_MODULUS) ? '0 : lcg_sum;

    // one restoring remainder step
    assign rem_shift = {rem_reg, raw_reg[RAW_W-1]};
    assign rem_sub   = rem_shift - span_reg;

    always_comb
    begin
        state_next   = state_reg;
        seed_next    = seed_reg;
        prod_next    = prod_reg;
        adv_cnt_next = adv_cnt_reg;
        kind_next    = kind_reg;
        low_next     = low_reg;
        span_next    = span_reg;
        err_next     = err_reg;
        raw_next     = raw_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        res_next     = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    kind_next    = kind_t'(s_axis_tuser);
                    low_next     = in_low;
                    // span in 33 bits: high - low + 1, 1 .. 2^32 when bounds are ordered
                    span_next    = SPAN_W'({in_high[SEED_W-1], in_high}
                                   - {in_low[SEED_W-1], in_low} + 33'd1);
                    err_next     = $signed(in_high) < $signed(in_low);
                    adv_cnt_next = mod3(seed_reg);
                    res_next     = '0;
                    case (kind_t'(s_axis_tuser))
                        KIND_RESEED:
                        begin
                            seed_next  = (in_seed != '0) ? in_seed : fallback_reg;
                            err_next   = 1'b0;
                            state_next = ST_OUT;
                        end
                        KIND_RAW, KIND_RANGE:
                        begin
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            err_next   = 1'b0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                prod_next  = SEED_W'(seed_reg * LCG_MULT);
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                seed_next = lcg_fold;
                if (adv_cnt_reg != '0)
                begin
                    adv_cnt_next = adv_cnt_reg - 2'd1;
                    state_next   = ST_MUL;
                end
                else if (kind_reg == KIND_RAW)
                begin
                    res_next   = SEED_W'(lcg_fold >> 1);
                    err_next   = 1'b0;
                    state_next = ST_OUT;
                end
                else if (err_reg)
                begin
                    res_next   = low_reg;
                    state_next = ST_OUT;
                end
                else
                begin
                    raw_next     = lcg_fold[SEED_W-1:1];
                    rem_next     = '0;
                    bit_cnt_next = BITCNT_W'(RAW_W - 1);
                    state_next   = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = rem_sub[SPAN_W-1] ? rem_shift[SEED_W-1:0] : rem_sub[SEED_W-1:0];
                raw_next = {raw_reg[RAW_W-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= SEED_RST;
            fallback_reg  <= FALLBACK_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            if (cfg_valid && cfg_ready)
            begin
                fallback_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        prod_reg    <= prod_next;
        adv_cnt_reg <= adv_cnt_next;
        kind_reg    <= kind_next;
        low_reg     <= low_next;
        span_reg    <= span_next;
        err_reg     <= err_next;
        raw_reg     <= raw_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        res_reg     <= res_next;
        if (state_reg == ST_OUT && out_free)
        begin
            // ranged draw result is low + remainder, wrapped to 32 bits
            if (kind_reg == KIND_RANGE && !err_reg)
            begin
                out_data_reg <= low_reg + rem_reg;
            end
            else
            begin
                out_data_reg <= res_reg;
            end
            out_err_reg <= err_reg && (kind_reg == KIND_RANGE);
        end
    end

endmodule
